>>> rtl/mpm_pkg.sv
// ----------------------------------------------------------------------------
// mpm_pkg: shared types and constants for the motion power-mode controller
// Field widths, mode and register codes, reset values, serial multiplier
// sizing and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mpm_pkg;

   // frame size is masked to this many bits
   localparam int SIZE_BITS    = 24;
   localparam int FRAME_SIZE_W = 24;
   localparam int NOW_W        = 32;
   localparam int MODE_W       = 2;
   localparam int DELAY_W      = 16;
   localparam int PCT_W        = 8;
   localparam int SEC_W        = 16;

   localparam int REQ_TDATA_W  = 56;   // frame_size, now_ms
   localparam int RSP_TDATA_W  = 24;   // mode, frame_delay_ms, zero pad

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   // serial multiplier sizing
   localparam int MPLIER_W = 10;
   localparam int MCAND_W  = (SIZE_BITS > SEC_W) ? SIZE_BITS : SEC_W;
   localparam int PROD_W   = MCAND_W + MPLIER_W;
   localparam int TCMP_W   = (PROD_W > NOW_W) ? PROD_W : NOW_W;
   localparam int CNT_W    = $clog2(MPLIER_W + 1);

   localparam logic [MPLIER_W-1:0] PCT_SCALE = MPLIER_W'(100);
   localparam logic [MPLIER_W-1:0] MS_PER_S  = MPLIER_W'(1000);

   // power modes
   localparam logic [MODE_W-1:0] MODE_FULL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LIGHT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DETECT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_PCT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_TO_LIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_TO_DET  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_DELAY   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_DELAY  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DETECT_DELAY = 3'd5;

   localparam logic [PCT_W-1:0]   RST_SIZE_PCT     = 8'd10;
   localparam logic [SEC_W-1:0]   RST_FULL_TO_LIGHT = 16'd30;
   localparam logic [SEC_W-1:0]   RST_LIGHT_TO_DET  = 16'd60;
   localparam logic [DELAY_W-1:0] RST_FULL_DELAY   = 16'd33;
   localparam logic [DELAY_W-1:0] RST_LIGHT_DELAY  = 16'd200;
   localparam logic [DELAY_W-1:0] RST_DETECT_DELAY = 16'd1000;

   typedef struct packed {
      logic [PCT_W-1:0]   size_change_percent;
      logic [SEC_W-1:0]   full_to_light_seconds;
      logic [SEC_W-1:0]   light_to_detect_seconds;
      logic [DELAY_W-1:0] full_delay_ms;
      logic [DELAY_W-1:0] light_delay_ms;
      logic [DELAY_W-1:0] detect_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

`default_nettype wire

>>> rtl/mpm_csr.sv
// ----------------------------------------------------------------------------
// mpm_csr: configuration registers
// Six threshold and delay registers written through an index/data channel.
// Unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mpm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mpm_pkg::CSR_DATA_W-1:0]    csr_data,
   output mpm_pkg::cfg_type                       cfg
);

   mpm_pkg::cfg_type cfg_ff;
   mpm_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mpm_pkg::REG_SIZE_PCT:
               cfg_in.size_change_percent = csr_data[mpm_pkg::PCT_W-1:0];
            mpm_pkg::REG_FULL_TO_LIGHT:
               cfg_in.full_to_light_seconds = csr_data[mpm_pkg::SEC_W-1:0];
            mpm_pkg::REG_LIGHT_TO_DET:
               cfg_in.light_to_detect_seconds = csr_data[mpm_pkg::SEC_W-1:0];
            mpm_pkg::REG_FULL_DELAY:
               cfg_in.full_delay_ms = csr_data[mpm_pkg::DELAY_W-1:0];
            mpm_pkg::REG_LIGHT_DELAY:
               cfg_in.light_delay_ms = csr_data[mpm_pkg::DELAY_W-1:0];
            mpm_pkg::REG_DETECT_DELAY:
               cfg_in.detect_delay_ms = csr_data[mpm_pkg::DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_change_percent     <= mpm_pkg::RST_SIZE_PCT;
         cfg_ff.full_to_light_seconds   <= mpm_pkg::RST_FULL_TO_LIGHT;
         cfg_ff.light_to_detect_seconds <= mpm_pkg::RST_LIGHT_TO_DET;
         cfg_ff.full_delay_ms           <= mpm_pkg::RST_FULL_DELAY;
         cfg_ff.light_delay_ms          <= mpm_pkg::RST_LIGHT_DELAY;
         cfg_ff.detect_delay_ms         <= mpm_pkg::RST_DETECT_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mpm_mul.sv
// ----------------------------------------------------------------------------
// mpm_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle, MSB first, and done pulses for
// one cycle when the product is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mpm_pkg::mul_req_type req,
   output mpm_pkg::mul_rsp_type      rsp
);

   logic [mpm_pkg::CNT_W-1:0]    cnt_ff,    cnt_in;
   logic                         done_ff,   done_in;
   logic [mpm_pkg::PROD_W-1:0]   acc_ff,    acc_in;
   logic [mpm_pkg::MCAND_W-1:0]  mcand_ff,  mcand_in;
   logic [mpm_pkg::MPLIER_W-1:0] mplier_ff, mplier_in;

   always_comb begin
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      done_in   = 1'b0;
      if (req.start) begin
         cnt_in    = mpm_pkg::CNT_W'(mpm_pkg::MPLIER_W);
         acc_in    = '0;
         mcand_in  = req.mcand;
         mplier_in = req.mplier;
      end else if (cnt_ff != '0) begin
         acc_in = {acc_ff[mpm_pkg::PROD_W-2:0], 1'b0}
                + (mplier_ff[mpm_pkg::MPLIER_W-1] ?
                   mpm_pkg::PROD_W'(mcand_ff) : '0);
         mplier_in = {mplier_ff[mpm_pkg::MPLIER_W-2:0], 1'b0};
         cnt_in    = cnt_ff - mpm_pkg::CNT_W'(1);
         done_in   = (cnt_ff == mpm_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign rsp.busy    = (cnt_ff != '0);
   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

   // done only follows the last step
   a_done_after_step: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(cnt_ff) == mpm_pkg::CNT_W'(1))
      else $error("multiplier done without final step");

endmodule

`default_nettype wire

>>> rtl/motion_power_mode_fsm.sv
// ----------------------------------------------------------------------------
// motion_power_mode_fsm: three-level power-mode controller
// Per frame report, decides motion (size change or gray flag), steps the
// power mode and reports the mode with its frame delay.
// ----------------------------------------------------------------------------
// Work: three passes of the 10-bit bit-serial multiplier (size change,
//   threshold, quiet time) between request and result.
// Flow: one request at a time; a waiting result sits in the output
//   register while the next request is worked.
// Reset (synchronous): full mode, stored size cleared, quiet start at 0,
//   registers to their defaults. No clearing pass.
`default_nettype none

module motion_power_mode_fsm (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [mpm_pkg::REQ_TDATA_W-1:0]      req_tdata,  // frame_size[23:0], now_ms[55:24]
   input  wire logic                                 req_tuser,  // gray_hit
   // result channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [mpm_pkg::RSP_TDATA_W-1:0]           rsp_tdata,  // mode[1:0], frame_delay_ms[17:2]
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mpm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mpm_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL_DIFF = 3'd1;
   localparam logic [2:0] S_MUL_SIZE = 3'd2;
   localparam logic [2:0] S_MUL_TIME = 3'd3;
   localparam logic [2:0] S_DONE     = 3'd4;

   mpm_pkg::cfg_type     cfg;
   mpm_pkg::mul_req_type mul_req;
   mpm_pkg::mul_rsp_type mul_rsp;

   logic [2:0]                           state_ff,   state_in;
   logic                                 start_ff,   start_in;
   logic [mpm_pkg::MODE_W-1:0]           mode_ff,    mode_in;
   logic [mpm_pkg::SIZE_BITS-1:0]        last_ff,    last_in;
   logic [mpm_pkg::NOW_W-1:0]            qstart_ff,  qstart_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   logic [mpm_pkg::SIZE_BITS-1:0]        sz_ff,      sz_in;
   logic [mpm_pkg::SIZE_BITS-1:0]        diff_ff,    diff_in;
   logic                                 gray_ff,    gray_in;
   logic [mpm_pkg::NOW_W-1:0]            now_ff,     now_in;
   logic [mpm_pkg::NOW_W-1:0]            elapsed_ff, elapsed_in;
   logic [mpm_pkg::PROD_W-1:0]           prod_a_ff,  prod_a_in;
   logic [mpm_pkg::PROD_W-1:0]           prod_b_ff,  prod_b_in;
   logic [mpm_pkg::PROD_W-1:0]           prod_c_ff,  prod_c_in;
   logic [mpm_pkg::MODE_W-1:0]           rsp_mode_ff,  rsp_mode_in;
   logic [mpm_pkg::DELAY_W-1:0]          rsp_delay_ff, rsp_delay_in;

   logic                                 accept;
   logic                                 commit;
   logic [mpm_pkg::SIZE_BITS-1:0]        in_sz;
   logic [mpm_pkg::NOW_W-1:0]            in_now;
   logic                                 motion;
   logic                                 quiet;

   mpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mpm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign in_sz  = mpm_pkg::SIZE_BITS'(req_tdata[mpm_pkg::FRAME_SIZE_W-1:0]);
   assign in_now = req_tdata[mpm_pkg::FRAME_SIZE_W +: mpm_pkg::NOW_W];

   // operands for the shared multiplier, one product per pass
   always_comb begin
      mul_req.start  = start_ff;
      mul_req.mcand  = '0;
      mul_req.mplier = '0;
      case (state_ff)
         S_MUL_DIFF: begin
            mul_req.mcand  = mpm_pkg::MCAND_W'(diff_ff);
            mul_req.mplier = mpm_pkg::PCT_SCALE;
         end
         S_MUL_SIZE: begin
            mul_req.mcand  = mpm_pkg::MCAND_W'(sz_ff);
            mul_req.mplier = mpm_pkg::MPLIER_W'(cfg.size_change_percent)
                           + mpm_pkg::MPLIER_W'(1);
         end
         S_MUL_TIME: begin
            mul_req.mcand  = (mode_ff == mpm_pkg::MODE_FULL) ?
                             mpm_pkg::MCAND_W'(cfg.full_to_light_seconds) :
                             mpm_pkg::MCAND_W'(cfg.light_to_detect_seconds);
            mul_req.mplier = mpm_pkg::MS_PER_S;
         end
         default: ;
      endcase
   end

   // floor(diff*100/sz) > pct  <=>  diff*100 >= (pct+1)*sz
   // floor(elapsed/1000) >= T  <=>  elapsed >= T*1000
   always_comb begin
      if (mode_ff == mpm_pkg::MODE_DETECT)
         motion = gray_ff;
      else if (sz_ff == '0 || last_ff == '0)
         motion = 1'b0;
      else
         motion = (prod_a_ff >= prod_b_ff);
      quiet = (mpm_pkg::TCMP_W'(elapsed_ff) >= mpm_pkg::TCMP_W'(prod_c_ff));
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      mode_in      = mode_ff;
      last_in      = last_ff;
      qstart_in    = qstart_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      sz_in        = sz_ff;
      diff_in      = diff_ff;
      gray_in      = gray_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      prod_c_in    = prod_c_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_delay_in = rsp_delay_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sz_in      = in_sz;
               diff_in    = (in_sz > last_ff) ? in_sz - last_ff : last_ff - in_sz;
               gray_in    = req_tuser;
               now_in     = in_now;
               elapsed_in = in_now - qstart_ff;
               state_in   = S_MUL_DIFF;
               start_in   = 1'b1;
            end
         end
         S_MUL_DIFF: begin
            if (mul_rsp.done) begin
               prod_a_in = mul_rsp.product;
               state_in  = S_MUL_SIZE;
               start_in  = 1'b1;
            end
         end
         S_MUL_SIZE: begin
            if (mul_rsp.done) begin
               prod_b_in = mul_rsp.product;
               state_in  = S_MUL_TIME;
               start_in  = 1'b1;
            end
         end
         S_MUL_TIME: begin
            if (mul_rsp.done) begin
               prod_c_in = mul_rsp.product;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (commit) begin
               if (mode_ff != mpm_pkg::MODE_DETECT && sz_ff != '0)
                  last_in = sz_ff;
               if (motion) begin
                  qstart_in = now_ff;
                  if (mode_ff != mpm_pkg::MODE_FULL) begin
                     mode_in = mpm_pkg::MODE_FULL;
                     last_in = '0;
                  end
               end else if (quiet && mode_ff == mpm_pkg::MODE_FULL) begin
                  mode_in   = mpm_pkg::MODE_LIGHT;
                  qstart_in = now_ff;
                  last_in   = '0;
               end else if (quiet && mode_ff == mpm_pkg::MODE_LIGHT) begin
                  mode_in   = mpm_pkg::MODE_DETECT;
                  qstart_in = now_ff;
                  last_in   = '0;
               end
               rsp_mode_in = mode_in;
               case (mode_in)
                  mpm_pkg::MODE_FULL:  rsp_delay_in = cfg.full_delay_ms;
                  mpm_pkg::MODE_LIGHT: rsp_delay_in = cfg.light_delay_ms;
                  default:             rsp_delay_in = cfg.detect_delay_ms;
               endcase
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         mode_ff      <= mpm_pkg::MODE_FULL;
         last_ff      <= '0;
         qstart_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         mode_ff      <= mode_in;
         last_ff      <= last_in;
         qstart_ff    <= qstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sz_ff        <= sz_in;
      diff_ff      <= diff_in;
      gray_ff      <= gray_in;
      now_ff       <= now_in;
      elapsed_ff   <= elapsed_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      prod_c_ff    <= prod_c_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_delay_ff <= rsp_delay_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mpm_pkg::RSP_TDATA_W - mpm_pkg::DELAY_W - mpm_pkg::MODE_W){1'b0}},
                        rsp_delay_ff, rsp_mode_ff};

   // a mode switch always clears the stored size
   a_switch_clears_size: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != $past(mode_ff)) |-> (last_ff == '0))
      else $error("mode switch left a stored frame size");

   // the quiet timer only restarts at the request's time
   a_qstart_from_now: assert property (@(posedge clock) disable iff (reset)
      (qstart_ff != $past(qstart_ff)) |-> (qstart_ff == now_ff))
      else $error("quiet start loaded from wrong source");

   // a new result only comes out of the decide step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside decide step");

   // multiplier is idle whenever a request can be taken
   a_idle_mul_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mul_rsp.busy)
      else $error("multiplier busy while idle");

endmodule

`default_nettype wire
